// ===== rtl/ccpp_pkg.sv =====
// Shared types and constants for the coin changer poll response parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ccpp_pkg;

    localparam int MAX_RESPONSE_BYTES = 16;
    localparam int POS_W = $clog2(MAX_RESPONSE_BYTES + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_SCALING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_HIGH  = 2'd2;

    localparam logic [4:0] STATUS_FIRST_KNOWN = 5'd1;
    localparam logic [4:0] STATUS_LAST_KNOWN  = 5'd13;
    localparam logic [4:0] STATUS_BUSY_A      = 5'd2;
    localparam logic [4:0] STATUS_BUSY_B      = 5'd10;
    localparam logic [4:0] STATUS_RESET       = 5'd11;

    typedef enum logic [2:0] {
        KIND_DISPENSE  = 3'd0,
        KIND_CREDITED  = 3'd1,
        KIND_REJECTED  = 3'd2,
        KIND_SLUG      = 3'd3,
        KIND_STATUS    = 3'd4,
        KIND_TUBE      = 3'd5,
        KIND_UNKNOWN   = 3'd6,
        KIND_IGNORED   = 3'd7
    } ccpp_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       eor;
    } ccpp_item_t;

endpackage

// ===== rtl/ccpp_cfg_regs.sv =====
// Configuration registers: coin scaling and the sixteen coin credit bytes.
// Gives the scaled credit of a coin type. Depends on ccpp_pkg.
`timescale 1ns / 1ps
module ccpp_cfg_regs
    import ccpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [3:0]           coin_type,
    output logic [15:0]          credit_add
);

    logic [7:0]  scaling_reg;
    logic [63:0] table_low_reg;
    logic [63:0] table_high_reg;
    logic [63:0] table_word;
    logic [7:0]  credit_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaling_reg    <= '0;
            table_low_reg  <= '0;
            table_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COIN_SCALING: scaling_reg    <= cfg_data[7:0];
                CFG_CREDIT_LOW:   table_low_reg  <= cfg_data;
                CFG_CREDIT_HIGH:  table_high_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        table_word  = coin_type[3] ? table_high_reg : table_low_reg;
        credit_byte = table_word[{coin_type[2:0], 3'b000} +: 8];
        credit_add  = credit_byte * scaling_reg;
    end

endmodule

// ===== rtl/ccpp_in_stage.sv =====
// Input register: holds one received byte and its end-of-response mark.
// Depends on ccpp_pkg.
`timescale 1ns / 1ps
module ccpp_in_stage
    import ccpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_response,
    output logic       item_valid,
    output ccpp_item_t item,
    input  logic       advance
);

    logic       valid_reg;
    logic       valid_next;
    ccpp_item_t item_reg;
    logic       accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rx_byte <= rx_byte;
            item_reg.eor     <= end_of_response;
        end
    end

endmodule

// ===== rtl/ccpp_classify.sv =====
// Byte classifier: response state, credit accumulation and result register.
// Depends on ccpp_pkg; takes scaled credit from ccpp_cfg_regs.
`timescale 1ns / 1ps
module ccpp_classify
    import ccpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  ccpp_item_t  item,
    output logic        advance,
    output logic [3:0]  lookup_type,
    input  logic [15:0] credit_add,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [3:0]  coin_type,
    output logic [4:0]  event_count,
    output logic [1:0]  route,
    output logic [4:0]  status_code,
    output logic [7:0]  tube_coins,
    output logic [31:0] credit_total,
    output logic        reset_seen,
    output logic        busy_seen,
    output logic        last
);

    logic             pending_reg, pending_next;
    logic             discard_reg, discard_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      credit_reg, credit_next;
    logic             rflag_reg, rflag_next;
    logic             bflag_reg, bflag_next;

    logic             out_valid_reg, out_valid_next;
    ccpp_kind_t       kind_reg, kind_next;
    logic [3:0]       type_reg, type_next;
    logic [4:0]       count_reg, count_next;
    logic [1:0]       route_reg, route_next;
    logic [4:0]       status_reg, status_next;
    logic [7:0]       tube_reg, tube_next;
    logic             last_reg;

    logic [7:0]       b;
    logic [4:0]       low5;
    logic [32:0]      sum;
    logic             beyond;

    assign advance     = item_valid && (!out_valid_reg || !out_stall);
    assign b           = item.rx_byte;
    assign low5        = b[4:0];
    assign lookup_type = b[3:0];
    assign sum         = {1'b0, credit_reg} + {17'd0, credit_add};
    assign beyond      = (pos_reg >= POS_W'(MAX_RESPONSE_BYTES));

    always_comb
    begin
        pending_next = pending_reg;
        discard_next = discard_reg;
        credit_next  = credit_reg;
        rflag_next   = rflag_reg;
        bflag_next   = bflag_reg;
        pos_next     = beyond ? pos_reg : pos_reg + POS_W'(1);
        kind_next    = KIND_IGNORED;
        type_next    = '0;
        count_next   = '0;
        route_next   = '0;
        status_next  = '0;
        tube_next    = '0;

        if (beyond || discard_reg)
        begin
            kind_next = KIND_IGNORED;
        end
        else if (pending_reg)
        begin
            kind_next    = KIND_TUBE;
            tube_next    = b;
            pending_next = 1'b0;
        end
        else if (b[7])
        begin
            kind_next    = KIND_DISPENSE;
            count_next   = {2'b00, b[6:4]};
            type_next    = b[3:0];
            pending_next = 1'b1;
        end
        else if (b[6])
        begin
            route_next   = b[5:4];
            type_next    = b[3:0];
            pending_next = 1'b1;
            if (!b[5])
            begin
                kind_next   = KIND_CREDITED;
                credit_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            else
            begin
                kind_next = KIND_REJECTED;
            end
        end
        else if (b[5])
        begin
            kind_next  = KIND_SLUG;
            count_next = low5;
        end
        else
        begin
            status_next = low5;
            if (low5 >= STATUS_FIRST_KNOWN && low5 <= STATUS_LAST_KNOWN)
            begin
                kind_next = KIND_STATUS;
                if (low5 == STATUS_BUSY_A || low5 == STATUS_BUSY_B)
                    bflag_next = 1'b1;
                if (low5 == STATUS_RESET)
                    rflag_next = 1'b1;
            end
            else
            begin
                kind_next    = KIND_UNKNOWN;
                discard_next = 1'b1;
            end
        end

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            discard_reg   <= 1'b0;
            pos_reg       <= '0;
            credit_reg    <= '0;
            rflag_reg     <= 1'b0;
            bflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                credit_reg <= credit_next;
                if (item.eor)
                begin
                    pending_reg <= 1'b0;
                    discard_reg <= 1'b0;
                    pos_reg     <= '0;
                    rflag_reg   <= 1'b0;
                    bflag_reg   <= 1'b0;
                end
                else
                begin
                    pending_reg <= pending_next;
                    discard_reg <= discard_next;
                    pos_reg     <= pos_next;
                    rflag_reg   <= rflag_next;
                    bflag_reg   <= bflag_next;
                end
            end
        end
    end

    // result payload; the seen flags are captured before end-of-response clears them
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg     <= kind_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
            route_reg    <= route_next;
            status_reg   <= status_next;
            tube_reg     <= tube_next;
            credit_total <= credit_next;
            reset_seen   <= rflag_next;
            busy_seen    <= bflag_next;
            last_reg     <= item.eor;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign coin_type   = type_reg;
    assign event_count = count_reg;
    assign route       = route_reg;
    assign status_code = status_reg;
    assign tube_coins  = tube_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/coin_changer_poll_parser.sv =====
// Top level of the coin changer poll response parser.
// Depends on ccpp_pkg, ccpp_cfg_regs, ccpp_in_stage and ccpp_classify.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  rx_byte, end_of_response
//   out      out_valid/ out_stall event_kind .. last (one result per byte)
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; each byte passes from the
// input register through classify and credit update into the result register
// (one 8x8 multiply and 32-bit saturating add between them).
// Reset clears the credit total, response state and all config registers.
// A stalled output holds its result and backs up into the input register.
`timescale 1ns / 1ps
module coin_changer_poll_parser
    import ccpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 end_of_response,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           event_kind,
    output logic [3:0]           coin_type,
    output logic [4:0]           event_count,
    output logic [1:0]           route,
    output logic [4:0]           status_code,
    output logic [7:0]           tube_coins,
    output logic [31:0]          credit_total,
    output logic                 reset_seen,
    output logic                 busy_seen,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic       item_valid;
    ccpp_item_t item;
    logic       advance;
    logic [3:0] lookup_type;
    logic [15:0] credit_add;

    ccpp_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coin_type  (lookup_type),
        .credit_add (credit_add)
    );

    ccpp_in_stage u_in (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .end_of_response (end_of_response),
        .item_valid      (item_valid),
        .item            (item),
        .advance         (advance)
    );

    ccpp_classify u_cls (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .advance      (advance),
        .lookup_type  (lookup_type),
        .credit_add   (credit_add),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .coin_type    (coin_type),
        .event_count  (event_count),
        .route        (route),
        .status_code  (status_code),
        .tube_coins   (tube_coins),
        .credit_total (credit_total),
        .reset_seen   (reset_seen),
        .busy_seen    (busy_seen),
        .last         (last)
    );

endmodule

// ===== sim/tb_coin_changer_poll_parser.sv =====
// Testbench for coin_changer_poll_parser: a directed table, then random poll responses,
// mostly with idling on both channels; results checked against table rows or a parser model.
// Depends on ccpp_pkg and the RTL of coin_changer_poll_parser.
`timescale 1ns / 1ps
module tb_coin_changer_poll_parser;
    import ccpp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 40;
    localparam int          PHASE_ITEMS  = 200;
    localparam int          SHOWN_ERRORS = 10;
    localparam logic [31:0] CREDIT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        ccpp_kind_t  kind;
        logic [3:0]  ctype;
        logic [4:0]  count;
        logic [1:0]  rte;
        logic [4:0]  status;
        logic [7:0]  tube;
        logic [31:0] credit;
        logic        rst_seen;
        logic        busy;
        logic        lst;
    } poll_event_t;

    typedef struct {
        logic [7:0]  b;
        logic        eor;
        int          reps;
        logic        typed;
        poll_event_t ev;
    } stim_row_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte         = '0;
    logic                 end_of_response = 1'b0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [2:0]           event_kind;
    logic [3:0]           coin_type;
    logic [4:0]           event_count;
    logic [1:0]           route;
    logic [4:0]           status_code;
    logic [7:0]           tube_coins;
    logic [31:0]          credit_total;
    logic                 reset_seen;
    logic                 busy_seen;
    logic                 last;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [63:0]          cfg_data        = '0;

    // parser model state and configuration copy
    logic [7:0]  m_scale     = '0;
    logic [63:0] m_lo        = '0;
    logic [63:0] m_hi        = '0;
    logic        m_tube_next = 1'b0;
    logic        m_discard   = 1'b0;
    logic        m_rst       = 1'b0;
    logic        m_busy      = 1'b0;
    int          m_pos       = 0;
    logic [31:0] m_total     = '0;

    poll_event_t pending_events[$];
    stim_row_t   dir_rows[$];
    int          fail_count   = 0;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    bit          src_idle_en  = 1'b0;
    bit          sink_idle_en = 1'b0;
    bit          hold_req     = 1'b0;

    coin_changer_poll_parser u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic poll_event_t parse_poll_byte(logic [7:0] b, logic eor);
        poll_event_t ev;
        logic [63:0] word;
        logic [15:0] add;
        logic [32:0] sum;
        ev = '0;
        ev.kind = KIND_IGNORED;
        if (m_pos >= MAX_RESPONSE_BYTES || m_discard)
        begin
            ev.kind = KIND_IGNORED;
        end
        else if (m_tube_next)
        begin
            ev.kind = KIND_TUBE;
            ev.tube = b;
            m_tube_next = 1'b0;
        end
        else if (b[7])
        begin
            ev.kind = KIND_DISPENSE;
            ev.count = {2'b00, b[6:4]};
            ev.ctype = b[3:0];
            m_tube_next = 1'b1;
        end
        else if (b[6])
        begin
            ev.rte = b[5:4];
            ev.ctype = b[3:0];
            if (!b[5])
            begin
                word = b[3] ? m_hi : m_lo;
                add = word[b[2:0]*8 +: 8] * m_scale;
                sum = {1'b0, m_total} + {17'd0, add};
                m_total = sum[32] ? CREDIT_MAX : sum[31:0];
                ev.kind = KIND_CREDITED;
            end
            else
            begin
                ev.kind = KIND_REJECTED;
            end
            m_tube_next = 1'b1;
        end
        else if (b[5])
        begin
            ev.kind = KIND_SLUG;
            ev.count = b[4:0];
        end
        else
        begin
            ev.status = b[4:0];
            if (b[4:0] >= STATUS_FIRST_KNOWN && b[4:0] <= STATUS_LAST_KNOWN)
            begin
                ev.kind = KIND_STATUS;
                if (b[4:0] == STATUS_BUSY_A || b[4:0] == STATUS_BUSY_B)
                    m_busy = 1'b1;
                if (b[4:0] == STATUS_RESET)
                    m_rst = 1'b1;
            end
            else
            begin
                ev.kind = KIND_UNKNOWN;
                m_discard = 1'b1;
            end
        end
        if (m_pos < 63)
            m_pos++;
        ev.credit = m_total;
        ev.rst_seen = m_rst;
        ev.busy = m_busy;
        ev.lst = eor;
        if (eor)
        begin
            m_tube_next = 1'b0;
            m_discard = 1'b0;
            m_pos = 0;
            m_rst = 1'b0;
            m_busy = 1'b0;
        end
        return ev;
    endfunction

    function automatic poll_event_t credit_free_event(ccpp_kind_t kind, logic [3:0] ctype,
                                                      logic [4:0] count, logic [4:0] status,
                                                      logic [7:0] tube, logic rs, logic bs,
                                                      logic lst);
        poll_event_t ev;
        ev = '0;
        ev.kind = kind;
        ev.ctype = ctype;
        ev.count = count;
        ev.status = status;
        ev.tube = tube;
        ev.rst_seen = rs;
        ev.busy = bs;
        ev.lst = lst;
        return ev;
    endfunction

    function automatic string show_event(poll_event_t e);
        return $sformatf({"kind=%0d type=%0d count=%0d route=%0d status=%0d tube=%0d ",
                          "credit=%0h rs=%0b bs=%0b last=%0b"},
                         e.kind, e.ctype, e.count, e.rte, e.status, e.tube, e.credit,
                         e.rst_seen, e.busy, e.lst);
    endfunction

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
            $display("%s", what);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eor, logic typed = 1'b0,
                             poll_event_t want = '0);
        poll_event_t predicted;
        if (src_idle_en && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        end_of_response <= eor;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = parse_poll_byte(b, eor);
        pending_events.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // build one response from event groups; broken ones lose tube bytes or their tail
    task automatic send_response(bit broken);
        logic [7:0] bytes[$];
        int         n;
        int         pick;
        logic [4:0] s;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 8);
        while (bytes.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if (pick < 20)
                    bytes.push_back({1'b1, 7'($urandom)});
                else
                    bytes.push_back({2'b01, 6'($urandom)});
                if (!(broken && $urandom_range(0, 3) == 0))
                    bytes.push_back(8'($urandom));
            end
            else if (pick < 60)
                bytes.push_back({3'b001, 5'($urandom)});
            else if (pick < 85)
                bytes.push_back({3'b000, 5'($urandom_range(1, 13))});
            else if (pick < 90)
            begin
                s = 5'($urandom_range(13, 31));
                if (s == 5'd13)
                    s = 5'd0;
                bytes.push_back({3'b000, s});
            end
            else
                bytes.push_back(8'($urandom));
        end
        if (broken && bytes.size() > 1)
            void'(bytes.pop_back());
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_config(logic [7:0] scale, logic [63:0] lo, logic [63:0] hi);
        put_reg(CFG_COIN_SCALING, {56'($urandom), scale});
        put_reg(CFG_CREDIT_LOW, lo);
        put_reg(CFG_CREDIT_HIGH, hi);
        put_reg(CFG_SPARE, {32'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
        m_scale = scale;
        m_lo = lo;
        m_hi = hi;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(logic [7:0] scale, logic [63:0] lo, logic [63:0] hi,
                              bit idle, bit squeeze);
        int start;
        wait_drained();
        load_config(scale, lo, hi);
        src_idle_en = idle;
        sink_idle_en = idle;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            if (squeeze && items_sent - start >= PHASE_ITEMS / 2)
            begin
                // hold the output while the input keeps offering
                squeeze = 1'b0;
                src_idle_en = 1'b0;
                hold_req = 1'b1;
                repeat (4) send_response(1'b0);
                src_idle_en = idle;
            end
            send_response($urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (sink_idle_en && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge clk)
    begin
        poll_event_t want;
        poll_event_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {event_kind, coin_type, event_count, route, status_code, tube_coins,
                    credit_total, reset_seen, busy_seen, last};
            if (pending_events.size() == 0)
            begin
                note_failure({"unexpected result: ", show_event(seen)});
            end
            else
            begin
                want = pending_events.pop_front();
                if (seen !== want)
                    note_failure({"mismatch\n  expected ", show_event(want),
                                  "\n  actual   ", show_event(seen)});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    initial
    begin
        dir_rows.push_back('{8'h00, 1'b1, 1, 1'b1, credit_free_event(KIND_UNKNOWN,
                             4'd0, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0, 1'b1)});
        dir_rows.push_back('{8'h1F, 1'b1, 1, 1'b1, credit_free_event(KIND_UNKNOWN,
                             4'd0, 5'd0, 5'd31, 8'd0, 1'b0, 1'b0, 1'b1)});
        dir_rows.push_back('{8'h0E, 1'b0, 1, 1'b1, credit_free_event(KIND_UNKNOWN,
                             4'd0, 5'd0, 5'd14, 8'd0, 1'b0, 1'b0, 1'b0)});
        dir_rows.push_back('{8'h01, 1'b1, 1, 1'b1, credit_free_event(KIND_IGNORED,
                             4'd0, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0, 1'b1)});
        dir_rows.push_back('{8'h02, 1'b0, 1, 1'b1, credit_free_event(KIND_STATUS,
                             4'd0, 5'd0, 5'd2, 8'd0, 1'b0, 1'b1, 1'b0)});
        dir_rows.push_back('{8'h0B, 1'b0, 1, 1'b1, credit_free_event(KIND_STATUS,
                             4'd0, 5'd0, 5'd11, 8'd0, 1'b1, 1'b1, 1'b0)});
        dir_rows.push_back('{8'h0D, 1'b1, 1, 1'b1, credit_free_event(KIND_STATUS,
                             4'd0, 5'd0, 5'd13, 8'd0, 1'b1, 1'b1, 1'b1)});
        dir_rows.push_back('{8'hFF, 1'b0, 1, 1'b1, credit_free_event(KIND_DISPENSE,
                             4'd15, 5'd7, 5'd0, 8'd0, 1'b0, 1'b0, 1'b0)});
        dir_rows.push_back('{8'h00, 1'b0, 1, 1'b1, credit_free_event(KIND_TUBE,
                             4'd0, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0, 1'b0)});
        dir_rows.push_back('{8'h80, 1'b0, 1, 1'b1, credit_free_event(KIND_DISPENSE,
                             4'd0, 5'd0, 5'd0, 8'd0, 1'b0, 1'b0, 1'b0)});
        dir_rows.push_back('{8'hFF, 1'b1, 1, 1'b1, credit_free_event(KIND_TUBE,
                             4'd0, 5'd0, 5'd0, 8'd255, 1'b0, 1'b0, 1'b1)});
        dir_rows.push_back('{8'h40, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'hA5, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h5F, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h00, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h3F, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h3F, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h20, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'hC3, 1'b1, 1, 1'b0, '0});
        dir_rows.push_back('{8'h0A, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h21, 1'b0, 14, 1'b0, '0});
        dir_rows.push_back('{8'h9A, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h33, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b1, 1, 1'b0, '0});
        dir_rows.push_back('{8'h45, 1'b0, 1, 1'b0, '0});
        dir_rows.push_back('{8'h12, 1'b1, 1, 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(8'hFF, '1, 64'h8070_6050_4030_2010);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        foreach (dir_rows[i])
            repeat (dir_rows[i].reps)
                send_byte(dir_rows[i].b, dir_rows[i].eor, dir_rows[i].typed, dir_rows[i].ev);

        run_random(8'h00, '0, '0, 1'b1, 1'b0);
        run_random(8'hFF, '1, '1, 1'b1, 1'b1);
        run_random(8'($urandom), {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)}, 1'b1, 1'b0);
        run_random(8'($urandom), {32'($urandom), 32'($urandom)},
                   {32'($urandom), 32'($urandom)}, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
